// ===== sv/ghbs_pkg.sv =====
// ghbs_pkg: shared types and constants for the grid height bilinear sampler
// used by every module but ghbs_queue; depends on nothing
`timescale 1ns / 1ps

package ghbs_pkg;

   localparam int GRID_AW  = 16;
   localparam int POS_BITS = 24;
   localparam int HEIGHT_W = 16;
   localparam int UV_W     = 24;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 33;

   typedef enum logic [CSR_IW-1:0] {
      CSR_GRID_COLS        = 3'd0,
      CSR_GRID_ROWS        = 3'd1,
      CSR_LON_LEFT         = 3'd2,
      CSR_LAT_BOTTOM       = 3'd3,
      CSR_CELLS_PER_DEGREE = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      logic        [8:0]  grid_cols;
      logic        [8:0]  grid_rows;
      logic signed [32:0] lon_left;
      logic signed [31:0] lat_bottom;
      logic        [15:0] cells_per_degree;
   } csr_type;

   // one classified request travelling from front to back
   typedef struct packed {
      logic                              is_write;
      logic                              in_range;
      logic [3:0][GRID_AW-1:0]           addr;
      logic [UV_W-1:0]                   u;
      logic [UV_W-1:0]                   v;
      logic [HEIGHT_W-1:0]               height;
   } job_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height_feet;
      logic                in_range;
   } result_type;

endpackage

// ===== sv/ghbs_queue.sv =====
// ghbs_queue: small synchronous fifo with occupancy count
// generic payload width; no package dependency
`timescale 1ns / 1ps

module ghbs_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output logic [$clog2(DEPTH):0]   count
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0]  slot_ff [DEPTH];
   logic [AW-1:0]     head_ff, head_in;
   logic [AW-1:0]     tail_ff, tail_in;
   logic [AW:0]       count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[head_ff];
   assign count    = count_ff;

endmodule

// ===== sv/ghbs_front.sv =====
// ghbs_front: maps a sample point to grid cells, fractions and range flag
// four register stages; uses ghbs_pkg types
`timescale 1ns / 1ps

module ghbs_front #(
   parameter int MAX_COLS  = 256,
   parameter int MAX_ROWS  = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  in_op,
   input  logic [15:0]           in_cell_index,
   input  logic signed [15:0]    in_cell_height,
   input  logic signed [31:0]    in_latitude,
   input  logic signed [32:0]    in_longitude,
   input  ghbs_pkg::csr_type     csr,
   output logic                  job_valid,
   output ghbs_pkg::job_type     job,
   output logic [2:0]            busy
);

   localparam int CW = $clog2(MAX_COLS + 1);
   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int PB = ghbs_pkg::POS_BITS;
   localparam int AW = ghbs_pkg::GRID_AW;
   localparam int MW = CW + RW + AW;

   // stage 1: offsets from tile corner
   logic                 v1_ff;
   logic                 op1_ff;
   logic [15:0]          idx1_ff;
   logic [15:0]          hgt1_ff;
   logic signed [33:0]   dlon1_ff;
   logic signed [32:0]   dlat1_ff;

   // stage 2: scaled to cells
   logic                 v2_ff;
   logic                 op2_ff;
   logic [15:0]          idx2_ff;
   logic [15:0]          hgt2_ff;
   logic signed [50:0]   px2_ff, px2_in;
   logic signed [49:0]   py2_ff, py2_in;

   // stage 3: range test, corner indices, fractions
   logic                 v3_ff;
   logic                 op3_ff;
   logic [15:0]          idx3_ff;
   logic [15:0]          hgt3_ff;
   logic                 rng3_ff, rng3_in;
   logic [CW-1:0]        x0_3_ff, x0_3_in, x1_3_ff, x1_3_in;
   logic [RW-1:0]        y0_3_ff, y0_3_in, y1_3_ff, y1_3_in;
   logic [FRAC_BITS-1:0] u3_ff, u3_in, v3f_ff, v3f_in;

   // stage 4: cell addresses
   logic                 v4_ff;
   ghbs_pkg::job_type    job4_ff, job4_in;

   logic [CW-1:0]        cols_eff;
   logic [RW-1:0]        rows_eff;
   logic signed [51:0]   xs, ys, col_lim, row_lim;
   logic [CW-1:0]        x0_raw;
   logic [RW-1:0]        y0_raw;
   logic [MW-1:0]        a00, a01, a10, a11;

   always_comb begin
      if (csr.grid_cols == '0) begin
         cols_eff = CW'(1);
      end else if (32'(csr.grid_cols) > 32'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(csr.grid_cols);
      end
      if (csr.grid_rows == '0) begin
         rows_eff = RW'(1);
      end else if (32'(csr.grid_rows) > 32'(MAX_ROWS)) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(csr.grid_rows);
      end
   end

   always_comb begin
      px2_in = dlon1_ff * $signed({1'b0, csr.cells_per_degree});
      py2_in = dlat1_ff * $signed({1'b0, csr.cells_per_degree});
   end

   always_comb begin
      col_lim = 52'(cols_eff) <<< PB;
      row_lim = 52'(rows_eff) <<< PB;
      xs      = 52'(px2_ff);
      ys      = row_lim - 52'(py2_ff);
      rng3_in = !xs[51] && (xs <= col_lim) && !ys[51] && (ys <= row_lim);
      x0_raw  = xs[PB +: CW];
      y0_raw  = ys[PB +: RW];
      u3_in   = xs[PB-1 -: FRAC_BITS];
      v3f_in  = ys[PB-1 -: FRAC_BITS];
      // clamp corners so the right and bottom edges sample inside the grid
      x0_3_in = (x0_raw > cols_eff - 1'b1) ? cols_eff - 1'b1 : x0_raw;
      y0_3_in = (y0_raw > rows_eff - 1'b1) ? rows_eff - 1'b1 : y0_raw;
      x1_3_in = (x0_3_in + 1'b1 > cols_eff - 1'b1) ? cols_eff - 1'b1 : x0_3_in + 1'b1;
      y1_3_in = (y0_3_in + 1'b1 > rows_eff - 1'b1) ? rows_eff - 1'b1 : y0_3_in + 1'b1;
   end

   always_comb begin
      a00 = MW'(y0_3_ff) * MW'(cols_eff) + MW'(x0_3_ff);
      a01 = MW'(y0_3_ff) * MW'(cols_eff) + MW'(x1_3_ff);
      a10 = MW'(y1_3_ff) * MW'(cols_eff) + MW'(x0_3_ff);
      a11 = MW'(y1_3_ff) * MW'(cols_eff) + MW'(x1_3_ff);
      job4_in.is_write = (op3_ff == ghbs_pkg::OP_WRITE);
      job4_in.in_range = rng3_ff;
      job4_in.u        = ghbs_pkg::UV_W'(u3_ff);
      job4_in.v        = ghbs_pkg::UV_W'(v3f_ff);
      job4_in.height   = hgt3_ff;
      if (op3_ff == ghbs_pkg::OP_WRITE) begin
         job4_in.addr[0] = idx3_ff;
      end else begin
         job4_in.addr[0] = a00[AW-1:0];
      end
      job4_in.addr[1] = a01[AW-1:0];
      job4_in.addr[2] = a10[AW-1:0];
      job4_in.addr[3] = a11[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= in_op;
      idx1_ff  <= in_cell_index;
      hgt1_ff  <= in_cell_height;
      dlon1_ff <= 34'(in_longitude) - 34'(csr.lon_left);
      dlat1_ff <= 33'(in_latitude) - 33'(csr.lat_bottom);
      op2_ff   <= op1_ff;
      idx2_ff  <= idx1_ff;
      hgt2_ff  <= hgt1_ff;
      px2_ff   <= px2_in;
      py2_ff   <= py2_in;
      op3_ff   <= op2_ff;
      idx3_ff  <= idx2_ff;
      hgt3_ff  <= hgt2_ff;
      rng3_ff  <= rng3_in;
      x0_3_ff  <= x0_3_in;
      x1_3_ff  <= x1_3_in;
      y0_3_ff  <= y0_3_in;
      y1_3_ff  <= y1_3_in;
      u3_ff    <= u3_in;
      v3f_ff   <= v3f_in;
      job4_ff  <= job4_in;
   end

   assign job_valid = v4_ff;
   assign job       = job4_ff;
   assign busy      = 3'(v1_ff) + 3'(v2_ff) + 3'(v3_ff) + 3'(v4_ff);

endmodule

// ===== sv/ghbs_back.sv =====
// ghbs_back: height grid memory, bilinear blend, rounding and saturation
// four register stages; uses ghbs_pkg types
`timescale 1ns / 1ps

module ghbs_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  ghbs_pkg::job_type      job,
   output logic                   res_valid,
   output ghbs_pkg::result_type   res,
   output logic [2:0]             busy
);

   localparam int F     = FRAC_BITS;
   localparam int DEPTH = 1 << ghbs_pkg::GRID_AW;
   localparam int TW    = F + 19;
   localparam int PW    = 2 * F + 22;
   localparam int FW    = F + 22;

   // one copy per corner so all four reads happen in the same cycle
   logic [15:0]          mem [4][DEPTH];

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                 rng1_ff, rng2_ff, rng3_ff;
   logic [F-1:0]         u1_ff, w1_ff, w2_ff;
   logic [15:0]          rd_ff [4];

   logic signed [TW-1:0] top2_ff, top2_in, bot2_ff, bot2_in;
   logic signed [TW-1:0] h00, h01, h10, h11, us;

   logic signed [PW-1:0] dd, ws, prod;
   logic signed [FW-1:0] fin3_ff, fin3_in;

   logic signed [FW-1:0] t, q;
   ghbs_pkg::result_type res4_ff, res4_in;

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (job_valid && job.is_write) begin
            mem[b][job.addr[0]] <= job.height;
         end
         rd_ff[b] <= mem[b][job.addr[b]];
      end
   end

   always_comb begin
      h00     = TW'($signed(rd_ff[0]));
      h01     = TW'($signed(rd_ff[1]));
      h10     = TW'($signed(rd_ff[2]));
      h11     = TW'($signed(rd_ff[3]));
      us      = TW'({1'b0, u1_ff});
      top2_in = (h00 <<< F) + (h01 - h00) * us;
      bot2_in = (h10 <<< F) + (h11 - h10) * us;
   end

   always_comb begin
      dd      = PW'(bot2_ff) - PW'(top2_ff);
      ws      = PW'({1'b0, w2_ff});
      prod    = dd * ws;
      fin3_in = FW'(top2_ff) + FW'(prod >>> F);
   end

   // add one half, then divide truncating toward zero
   always_comb begin
      t = fin3_ff + (FW'(1) <<< (F - 1));
      q = t >>> F;
      if (t[FW-1] && (t[F-1:0] != '0)) begin
         q = q + FW'(1);
      end
      res4_in.in_range = rng3_ff;
      if (!rng3_ff) begin
         res4_in.height_feet = '0;
      end else if (q > FW'(32767)) begin
         res4_in.height_feet = 16'h7fff;
      end else if (q < FW'(-32768)) begin
         res4_in.height_feet = 16'h8000;
      end else begin
         res4_in.height_feet = q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= job_valid && !job.is_write;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      rng1_ff <= job.in_range;
      u1_ff   <= job.u[F-1:0];
      w1_ff   <= job.v[F-1:0];
      rng2_ff <= rng1_ff;
      w2_ff   <= w1_ff;
      top2_ff <= top2_in;
      bot2_ff <= bot2_in;
      rng3_ff <= rng2_ff;
      fin3_ff <= fin3_in;
      res4_ff <= res4_in;
   end

   assign res_valid = v4_ff;
   assign res       = res4_ff;
   assign busy      = 3'(v1_ff) + 3'(v2_ff) + 3'(v3_ff) + 3'(v4_ff);

endmodule

// ===== sv/grid_height_bilinear_sampler_top.sv =====
// Grid height bilinear sampler. One request is taken per clock unless stalled:
// a write stores one 16-bit cell, a sample returns one interpolated height with
// a range flag. A sample passes four front stages (offset, scale, range and
// clamp, cell address), the job queue, four back stages (grid read, row blend,
// column blend, round and saturate) and the result queue. The four corner reads
// come from four copies of the 64K-cell grid, one per corner, so the grid serves
// a full sample every cycle. A cell must be written before it is sampled. The
// user must write configuration registers only while the block is idle; the
// block does not enforce this. Top level; uses ghbs_pkg, ghbs_front, ghbs_queue and ghbs_back
`timescale 1ns / 1ps

module grid_height_bilinear_sampler_top #(
   parameter int MAX_COLS  = 256,
   parameter int MAX_ROWS  = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [15:0]                         req_cell_index,
   input  logic signed [15:0]                  req_cell_height,
   input  logic signed [31:0]                  req_latitude,
   input  logic signed [32:0]                  req_longitude,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_height_feet,
   output logic                                rsp_in_range,
   input  logic                                csr_we,
   input  logic [ghbs_pkg::CSR_IW-1:0]         csr_index,
   input  logic [ghbs_pkg::CSR_DW-1:0]         csr_wdata
);

   localparam int QD = 8;
   localparam int QC = $clog2(QD) + 1;

   ghbs_pkg::csr_type    csr_ff, csr_in;

   logic                 req_accept;
   logic                 job_valid;
   ghbs_pkg::job_type    job_push, job_head;
   logic [QC-1:0]        jq_count;
   logic [2:0]           front_busy, back_busy;
   logic                 job_pop;

   logic                 res_valid;
   ghbs_pkg::result_type res_push, res_head;
   logic [QC-1:0]        rq_count;
   logic                 rsp_pop;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            ghbs_pkg::CSR_GRID_COLS:        csr_in.grid_cols = csr_wdata[8:0];
            ghbs_pkg::CSR_GRID_ROWS:        csr_in.grid_rows = csr_wdata[8:0];
            ghbs_pkg::CSR_LON_LEFT:         csr_in.lon_left = csr_wdata[32:0];
            ghbs_pkg::CSR_LAT_BOTTOM:       csr_in.lat_bottom = csr_wdata[31:0];
            ghbs_pkg::CSR_CELLS_PER_DEGREE: csr_in.cells_per_degree = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.grid_cols        <= 9'd256;
         csr_ff.grid_rows        <= 9'd256;
         csr_ff.lon_left         <= '0;
         csr_ff.lat_bottom       <= '0;
         csr_ff.cells_per_degree <= 16'd3600;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front never stalls: only take a request when the queue has room for it
   assign req_stall  = ((QC + 1)'(jq_count) + (QC + 1)'(front_busy)) >= (QC + 1)'(QD);
   assign req_accept = req_valid && !req_stall;

   ghbs_front #(
      .MAX_COLS  (MAX_COLS),
      .MAX_ROWS  (MAX_ROWS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_accept),
      .in_op          (req_op),
      .in_cell_index  (req_cell_index),
      .in_cell_height (req_cell_height),
      .in_latitude    (req_latitude),
      .in_longitude   (req_longitude),
      .csr            (csr_ff),
      .job_valid      (job_valid),
      .job            (job_push),
      .busy           (front_busy)
   );

   ghbs_queue #(
      .WIDTH ($bits(ghbs_pkg::job_type)),
      .DEPTH (QD)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_data (job_push),
      .pop       (job_pop),
      .pop_data  (job_head),
      .count     (jq_count)
   );

   // back issues only when the result queue can hold everything in flight
   assign job_pop = (jq_count != '0) &&
                    (((QC + 1)'(rq_count) + (QC + 1)'(back_busy)) < (QC + 1)'(QD));

   ghbs_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_pop),
      .job       (job_head),
      .res_valid (res_valid),
      .res       (res_push),
      .busy      (back_busy)
   );

   ghbs_queue #(
      .WIDTH ($bits(ghbs_pkg::result_type)),
      .DEPTH (QD)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_push),
      .pop       (rsp_pop),
      .pop_data  (res_head),
      .count     (rq_count)
   );

   assign rsp_valid       = (rq_count != '0);
   assign rsp_pop         = rsp_valid && !rsp_stall;
   assign rsp_height_feet = res_head.height_feet;
   assign rsp_in_range    = res_head.in_range;

endmodule

// ===== tb/tb_grid_height_bilinear_sampler_top.sv =====
// testbench for grid_height_bilinear_sampler_top: random and directed requests
// checked against a cycle-free height predictor; uses ghbs_pkg and the top level
`timescale 1ns / 1ps

class height_scoreboard;
   bit [15:0]        grid [0:65535];
   bit [8:0]         cols_r = 9'd256;
   bit [8:0]         rows_r = 9'd256;
   bit signed [32:0] lon_left = '0;
   bit signed [31:0] lat_bottom = '0;
   bit [15:0]        cpd = 16'd3600;
   bit [15:0]        exp_height [$];
   bit               exp_range [$];
   int               errors = 0;

   function int eff_size(bit [8:0] v);
      return (v == 0) ? 1 : ((v > 256) ? 256 : int'(v));
   endfunction

   function void set_reg(ghbs_pkg::csr_index_type idx, longint val);
      case (idx)
         ghbs_pkg::CSR_GRID_COLS:        cols_r = val[8:0];
         ghbs_pkg::CSR_GRID_ROWS:        rows_r = val[8:0];
         ghbs_pkg::CSR_LON_LEFT:         lon_left = val[32:0];
         ghbs_pkg::CSR_LAT_BOTTOM:       lat_bottom = val[31:0];
         ghbs_pkg::CSR_CELLS_PER_DEGREE: cpd = val[15:0];
         default: ;
      endcase
   endfunction

   function longint cell_at(longint r, longint c, longint ncols);
      bit [15:0] a;
      a = 16'(r * ncols + c);
      return longint'($signed(grid[a]));
   endfunction

   // expected height for one accepted request
   function void note_request(ghbs_pkg::op_type op, bit [15:0] idx, bit [15:0] h,
                              bit signed [31:0] lat, bit signed [32:0] lon);
      longint c, r, x, y, one24, x0, y0, x1, y1, u, v;
      longint h00, h01, h10, h11, top, bot, fin, res;
      if (op == ghbs_pkg::OP_WRITE) begin
         grid[idx] = h;
         return;
      end
      c = eff_size(cols_r);
      r = eff_size(rows_r);
      one24 = 64'sd1 <<< 24;
      x = (longint'(lon) - longint'(lon_left)) * longint'(cpd);
      y = r * one24 - (longint'(lat) - longint'(lat_bottom)) * longint'(cpd);
      if (x < 0 || x > c * one24 || y < 0 || y > r * one24) begin
         exp_height.push_back(16'd0);
         exp_range.push_back(1'b0);
         return;
      end
      x0 = x >>> 24;
      y0 = y >>> 24;
      u = (x & (one24 - 1)) >>> 8;
      v = (y & (one24 - 1)) >>> 8;
      if (x0 > c - 1) x0 = c - 1;
      if (y0 > r - 1) y0 = r - 1;
      x1 = (x0 + 1 > c - 1) ? c - 1 : x0 + 1;
      y1 = (y0 + 1 > r - 1) ? r - 1 : y0 + 1;
      h00 = cell_at(y0, x0, c);
      h01 = cell_at(y0, x1, c);
      h10 = cell_at(y1, x0, c);
      h11 = cell_at(y1, x1, c);
      top = h00 * 65536 + u * (h01 - h00);
      bot = h10 * 65536 + u * (h11 - h10);
      fin = top + ((v * (bot - top)) >>> 16);
      res = (fin + 32768) / 65536;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      exp_height.push_back(16'(res));
      exp_range.push_back(1'b1);
   endfunction

   function void check_result(bit [15:0] h, bit rng);
      bit [15:0] eh;
      bit        er;
      if (exp_height.size() == 0) begin
         $error("unexpected result height_feet=%0d in_range=%0b", $signed(h), rng);
         errors++;
         return;
      end
      eh = exp_height.pop_front();
      er = exp_range.pop_front();
      if (eh !== h) begin
         $error("height_feet expected %0d actual %0d", $signed(eh), $signed(h));
         errors++;
      end
      if (er !== rng) begin
         $error("in_range expected %0b actual %0b", er, rng);
         errors++;
      end
   endfunction

   function int pending();
      return exp_height.size();
   endfunction
endclass

module tb_grid_height_bilinear_sampler_top;
   localparam int LIMIT = 600000;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_op = ghbs_pkg::OP_WRITE;
   logic [15:0]                 req_cell_index = '0;
   logic signed [15:0]          req_cell_height = '0;
   logic signed [31:0]          req_latitude = '0;
   logic signed [32:0]          req_longitude = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [15:0]          rsp_height_feet;
   logic                        rsp_in_range;
   logic                        csr_we = 1'b0;
   logic [ghbs_pkg::CSR_IW-1:0] csr_index = '0;
   logic [ghbs_pkg::CSR_DW-1:0] csr_wdata = '0;

   height_scoreboard sb = new();
   int  cycles = 0;
   int  burst_left = 0;
   bit  hold_req = 1'b0;
   int  hold_cnt = 0;

   grid_height_bilinear_sampler_top dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // receiver: stall density follows a randomly drawn mode, plus a long hold-off in phases with seven columns
   initial begin
      int mode;
      mode = 0;
      forever begin
         @(negedge clock);
         if (cycles % 64 == 0) mode = $urandom_range(0, 3);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 500;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall = 1'b1;
         end else begin
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               2: rsp_stall = ($urandom_range(0, 3) != 0);
               default: rsp_stall = ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_height_feet, rsp_in_range);
   end

   task automatic send(ghbs_pkg::op_type op, bit [15:0] idx, bit [15:0] h,
                       bit signed [31:0] lat, bit signed [32:0] lon);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_op = op;
      req_cell_index = idx;
      req_cell_height = h;
      req_latitude = lat;
      req_longitude = lon;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, idx, h, lat, lon);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      // writes produce no result and may still be in flight
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(ghbs_pkg::csr_index_type idx, longint val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val[32:0];
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_reg(idx, val);
   endtask

   function automatic bit [15:0] rand_height();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(0, 200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   // point from a column/row position in cells with 24 fraction bits
   task automatic sample_at(longint xpos, longint ypos);
      longint lon, lat, r, k;
      r = sb.eff_size(sb.rows_r);
      k = longint'(sb.cpd);
      if (k == 0) begin
         lon = sb.lon_left + xpos;
         lat = sb.lat_bottom - ypos;
      end else begin
         lon = sb.lon_left + xpos / k;
         lat = sb.lat_bottom + (r * (64'sd1 <<< 24) - ypos) / k;
      end
      send(ghbs_pkg::OP_SAMPLE, 16'($urandom), 16'($urandom), 32'(lat), 33'(lon));
   endtask

   task automatic noise_sample();
      longint lat, lon;
      lat = longint'($urandom) % 64'sd1509949441;
      lon = (longint'($urandom) * 2 + $urandom_range(0, 1)) % 64'sd3019898881;
      if ($urandom_range(0, 1)) lat = -lat;
      if ($urandom_range(0, 1)) lon = -lon;
      send(ghbs_pkg::OP_SAMPLE, 16'($urandom), 16'($urandom), 32'(lat), 33'(lon));
   endtask

   task automatic run_phase(int cols, int rows, longint lonl, longint latb, int cpd,
                            int nrand, bit directed);
      int c, r, k;
      longint one24, xr, yr;
      one24 = 64'sd1 <<< 24;
      wait_idle();
      write_reg(ghbs_pkg::CSR_GRID_COLS, cols);
      write_reg(ghbs_pkg::CSR_GRID_ROWS, rows);
      write_reg(ghbs_pkg::CSR_LON_LEFT, lonl);
      write_reg(ghbs_pkg::CSR_LAT_BOTTOM, latb);
      write_reg(ghbs_pkg::CSR_CELLS_PER_DEGREE, cpd);
      c = sb.eff_size(sb.cols_r);
      r = sb.eff_size(sb.rows_r);
      // load every cell so no sample touches an unwritten one
      for (k = 0; k < c * r; k++) send(ghbs_pkg::OP_WRITE, 16'(k), rand_height(), '0, '0);
      xr = c * one24;
      yr = r * one24;
      if (directed) begin
         sample_at(0, 0);
         sample_at(xr, 0);
         sample_at(0, yr);
         sample_at(xr, yr);
         sample_at(xr / 2, yr / 2);
         sample_at(xr - 1, yr - 1);
         sample_at(-one24, 0);
         sample_at(0, yr + 2 * one24);
         sample_at(xr + 2 * one24, 0);
         sample_at(0, -2 * one24);
         send(ghbs_pkg::OP_SAMPLE, 0, 0, 32'sh7fff_ffff, 33'sh0_7fff_ffff);
         send(ghbs_pkg::OP_SAMPLE, 16'hffff, 16'hffff, -32'sd1509949440, -33'sd3019898880);
         send(ghbs_pkg::OP_SAMPLE, 0, 0, 32'sd1509949440, 33'sd3019898880);
         send(ghbs_pkg::OP_WRITE, 16'hffff, 16'h8000, '0, '0);
         send(ghbs_pkg::OP_WRITE, 16'h0000, 16'h7fff, '0, '0);
         sample_at(0, 0);
         sample_at(one24 / 2, one24 / 2);
      end
      for (k = 0; k < nrand; k++) begin
         case ($urandom_range(0, 9))
            0: noise_sample();
            1, 2: send(ghbs_pkg::OP_WRITE, 16'($urandom), rand_height(), 32'($urandom),
                       33'({$urandom, 1'b0}));
            3: sample_at(($urandom_range(0, 1) ? xr : 0) + int'($urandom_range(0, 64)) - 32,
                         ($urandom_range(0, 1) ? yr : 0) + int'($urandom_range(0, 64)) - 32);
            default: sample_at(longint'($urandom_range(0, c * 1024)) * 16384
                               + $urandom_range(0, 16383),
                               longint'($urandom_range(0, r * 1024)) * 16384
                               + $urandom_range(0, 16383));
         endcase
         if (k == nrand / 3 && hold_cnt == 0 && cols == 7) hold_req = 1'b1;
      end
   endtask

   initial begin
      int p;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_phase(4, 3, 64'sd150000000, -64'sd80000000, 3600, 60, 1'b1);
      run_phase(7, 5, -64'sd3019898880, 64'sd1509949440, 65535, 200, 1'b0);
      run_phase(256, 1, 64'sd3019898880, -64'sd1509949440, 1, 60, 1'b1);
      run_phase(1, 256, 0, 0, 0, 60, 1'b0);
      run_phase(0, 0, -64'sd12345678, 64'sd7654321, 3600, 40, 1'b1);
      run_phase(511, 1, 0, 0, 40000, 60, 1'b0);
      for (p = 0; p < 8; p++)
         run_phase($urandom_range(1, 12), $urandom_range(1, 12),
                   longint'($urandom_range(0, 2000000000)) - 1000000000,
                   longint'($urandom_range(0, 2000000000)) - 1000000000,
                   $urandom_range(1, 65535), 30, 1'b0);
      wait_idle();
      repeat (30) @(posedge clock);
      if (sb.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
sv/ghbs_pkg.sv
sv/ghbs_queue.sv
sv/ghbs_front.sv
sv/ghbs_back.sv
sv/grid_height_bilinear_sampler_top.sv
tb/tb_grid_height_bilinear_sampler_top.sv
